// ----- rtl/pngu_pkg.sv -----
// ----------------------------------------------------------------------------
// pngu_pkg: shared types and constants of the PNG scanline unfilter
// Holds the field widths, the row buffer size, the filter type codes and the
// structs that travel between the front end, the item queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pngu_pkg;

  // Row buffer size in bytes and the index widths that follow from it.
  localparam int MAX_ROW_BYTES = 8192;
  localparam int COL_W         = $clog2(MAX_ROW_BYTES);
  localparam int ROWLEN_W      = $clog2(MAX_ROW_BYTES + 1);

  // Configuration field widths.
  localparam int WIDTH_W    = 14;
  localparam int HEIGHT_W   = 16;
  localparam int BPP_W      = 2;
  localparam int PROD_W     = WIDTH_W + BPP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Byte width of the data path.
  localparam int BYTE_W = 8;

  // Highest filter type code that names a real filter.
  localparam logic [BYTE_W-1:0] FILTER_LAST = 8'd4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_BYTES_PER_PIXEL = 2'd2
  } cfg_reg_t;

  // Filter types as coded in the row's leading byte.
  typedef enum logic [2:0] {
    FLT_NONE    = 3'd0,
    FLT_SUB     = 3'd1,
    FLT_UP      = 3'd2,
    FLT_AVERAGE = 3'd3,
    FLT_PAETH   = 3'd4
  } filter_t;

  // One classified row byte, handed from the front end to the back end.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [COL_W-1:0]  col;
    logic [1:0]        lag;       // bytes per pixel minus one
    logic              has_left;  // a left neighbor exists in this row
    logic              has_up;    // a row above exists in this image
    filter_t           kind;
    logic              unknown;
    logic              row_end;
    logic              image_end;
  } item_t;

  // One reconstructed byte with its flags.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              row_end;
    logic              image_end;
    logic              unknown;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/pngu_ram.sv -----
// ----------------------------------------------------------------------------
// pngu_ram: generic simple dual-port RAM
// One write port and one read port with enable; read data is registered and
// shows the old contents when the same address is written in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/pngu_front.sv -----
// ----------------------------------------------------------------------------
// pngu_front: byte intake and classification
// Holds the configuration registers, takes the filter type byte of each row,
// counts columns and rows and tags every row byte with its neighbors and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_front
  import pngu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [BYTE_W-1:0]     in_byte,
  output logic                       in_full,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       cfg_ready,
  input  wire logic                  q_full,
  output logic                       q_push,
  output item_t                      q_item
);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [BPP_W-1:0]    bpp_r;

  logic                await_r;
  filter_t             kind_r;
  logic                unknown_r;
  logic [COL_W-1:0]    col_r;
  logic [HEIGHT_W-1:0] row_r;

  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [BPP_W-1:0]    bpp_eff;
  logic [PROD_W-1:0]   prod;
  logic [ROWLEN_W-1:0] row_len;
  logic [ROWLEN_W-1:0] col_next;
  logic                last_col;
  logic                last_row;
  logic                accept;
  filter_t             kind_in;
  logic                unknown_in;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(1);
      height_r <= HEIGHT_W'(1);
      bpp_r    <= BPP_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:     width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:    height_r <= cfg_data[HEIGHT_W-1:0];
        CFG_BYTES_PER_PIXEL: bpp_r    <= cfg_data[BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero in any geometry register counts as one.
  assign width_eff  = (width_r == '0) ? WIDTH_W'(1) : width_r;
  assign height_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  assign bpp_eff    = (bpp_r == '0) ? BPP_W'(1) : bpp_r;

  // Row length in bytes, saturated at the row buffer size.
  assign prod    = PROD_W'(width_eff) * PROD_W'(bpp_eff);
  assign row_len = (32'(prod) > 32'(MAX_ROW_BYTES)) ? ROWLEN_W'(MAX_ROW_BYTES)
                                                    : ROWLEN_W'(prod);

  // End of row and end of image detection for the current byte.
  assign col_next = ROWLEN_W'(col_r) + ROWLEN_W'(1);
  assign last_col = (col_next >= row_len);
  assign last_row = ((17'(row_r) + 17'd1) >= 17'(height_eff));

  // A filter type byte needs no queue space.
  assign in_full = !await_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = accept && !await_r;

  // Filter type codes above the last one fall back to None and are flagged.
  always_comb begin
    if (in_byte > FILTER_LAST) begin
      kind_in    = FLT_NONE;
      unknown_in = 1'b1;
    end else begin
      kind_in    = filter_t'(in_byte[2:0]);
      unknown_in = 1'b0;
    end
  end

  // Tag the row byte for the back end.
  always_comb begin
    q_item           = '0;
    q_item.data      = in_byte;
    q_item.col       = col_r;
    q_item.lag       = 2'(bpp_eff - BPP_W'(1));
    q_item.has_left  = (col_r >= COL_W'(bpp_eff));
    q_item.has_up    = (row_r != '0);
    q_item.kind      = kind_r;
    q_item.unknown   = unknown_r;
    q_item.row_end   = last_col;
    q_item.image_end = last_col && last_row;
  end

  // Row and column tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r   <= 1'b1;
      kind_r    <= FLT_NONE;
      unknown_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
    end else if (accept) begin
      if (await_r) begin
        kind_r    <= kind_in;
        unknown_r <= unknown_in;
        await_r   <= 1'b0;
        col_r     <= '0;
      end else if (last_col) begin
        await_r <= 1'b1;
        col_r   <= '0;
        row_r   <= last_row ? '0 : row_r + HEIGHT_W'(1);
      end else begin
        col_r <= col_next[COL_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pngu_item_queue.sv -----
// ----------------------------------------------------------------------------
// pngu_item_queue: two-entry queue of classified row bytes
// Parts the front end from the back end so that each can stall on its own
// while a byte per cycle still flows when neither side waits.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_item_queue
  import pngu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  item_t     push_item,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output item_t     head
);

  item_t       slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pngu_back.sv -----
// ----------------------------------------------------------------------------
// pngu_back: byte reconstruction
// Reads the up neighbor from the row buffer, applies the row's filter with the
// left and upper-left history, writes the result back and buffers it for output.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_back
  import pngu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  item_t      q_head,
  output logic       q_pop,
  output logic       out_empty,
  input  wire logic  out_pop,
  output result_t    out_result
);

  item_t             s2_item_r;
  logic              s2_valid_r;
  logic              fwd_r;
  logic [BYTE_W-1:0] fwd_data_r;
  logic [BYTE_W-1:0] left_r [3];
  logic [BYTE_W-1:0] upleft_r [3];

  result_t           ob_slot_r [2];
  logic              ob_wr_ptr_r;
  logic              ob_rd_ptr_r;
  logic [1:0]        ob_count_r;

  logic              ob_full;
  logic              ob_pop;
  logic              s2_done;
  logic              s2_load;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] left_sel;
  logic [BYTE_W-1:0] upleft_sel;
  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] c;
  logic [BYTE_W-1:0] pred;
  logic [BYTE_W-1:0] paeth_pick;
  logic [BYTE_W:0]   avg_sum;
  logic signed [9:0] diff_a;
  logic signed [9:0] diff_b;
  logic signed [9:0] diff_c;
  logic signed [9:0] dist_a;
  logic signed [9:0] dist_b;
  logic signed [9:0] dist_c;
  logic [BYTE_W-1:0] result;
  result_t           s2_result;

  // Stage advance: the reconstruction stage finishes when the output buffer
  // has room, and takes the queue head whenever it is empty or finishing.
  assign ob_full = (ob_count_r == 2'd2);
  assign s2_done = s2_valid_r && !ob_full;
  assign s2_load = !q_empty && (!s2_valid_r || s2_done);
  assign q_pop   = s2_load;

  // Row buffer holding the reconstructed bytes of the row above.
  pngu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_ram (
    .clk   (clk),
    .we    (s2_done),
    .waddr (s2_item_r.col),
    .wdata (result),
    .re    (s2_load),
    .raddr (q_head.col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= 1'b1;
    end else if (s2_done) begin
      s2_valid_r <= 1'b0;
    end
  end

  // Stage payload, plus a bypass for a read of the entry written in the same
  // cycle, which happens when a row is one byte long.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_item_r  <= q_head;
      fwd_r      <= s2_done && (s2_item_r.col == q_head.col);
      fwd_data_r <= result;
    end
  end

  // Pick the history entry one pixel back.
  always_comb begin
    unique case (s2_item_r.lag)
      2'd0: begin
        left_sel   = left_r[0];
        upleft_sel = upleft_r[0];
      end
      2'd1: begin
        left_sel   = left_r[1];
        upleft_sel = upleft_r[1];
      end
      default: begin
        left_sel   = left_r[2];
        upleft_sel = upleft_r[2];
      end
    endcase
  end

  // Neighbors; a missing one counts as zero.
  assign a = s2_item_r.has_left ? left_sel : '0;
  assign b = s2_item_r.has_up ? (fwd_r ? fwd_data_r : ram_rdata) : '0;
  assign c = (s2_item_r.has_left && s2_item_r.has_up) ? upleft_sel : '0;

  // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
  assign diff_a = $signed({2'b00, b}) - $signed({2'b00, c});
  assign diff_b = $signed({2'b00, a}) - $signed({2'b00, c});
  assign diff_c = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
  assign dist_a = (diff_a < 0) ? -diff_a : diff_a;
  assign dist_b = (diff_b < 0) ? -diff_b : diff_b;
  assign dist_c = (diff_c < 0) ? -diff_c : diff_c;

  // Ties go to left, then up, then upper-left.
  always_comb begin
    priority if ((dist_a <= dist_b) && (dist_a <= dist_c)) begin
      paeth_pick = a;
    end else if (dist_b <= dist_c) begin
      paeth_pick = b;
    end else begin
      paeth_pick = c;
    end
  end

  assign avg_sum = {1'b0, a} + {1'b0, b};

  // Predictor for the row's filter.
  always_comb begin
    unique case (s2_item_r.kind)
      FLT_NONE:    pred = '0;
      FLT_SUB:     pred = a;
      FLT_UP:      pred = b;
      FLT_AVERAGE: pred = avg_sum[BYTE_W:1];
      FLT_PAETH:   pred = paeth_pick;
      default:     pred = '0;
    endcase
  end

  assign result = s2_item_r.data + pred;

  // Left and upper-left history, newest first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        left_r[i]   <= '0;
        upleft_r[i] <= '0;
      end
    end else if (s2_done) begin
      left_r[2]   <= left_r[1];
      left_r[1]   <= left_r[0];
      left_r[0]   <= result;
      upleft_r[2] <= upleft_r[1];
      upleft_r[1] <= upleft_r[0];
      upleft_r[0] <= b;
    end
  end

  always_comb begin
    s2_result           = '0;
    s2_result.data      = result;
    s2_result.row_end   = s2_item_r.row_end;
    s2_result.image_end = s2_item_r.image_end;
    s2_result.unknown   = s2_item_r.unknown;
  end

  // Two-entry output buffer.
  assign ob_pop     = out_pop && !out_empty;
  assign out_empty  = (ob_count_r == 2'd0);
  assign out_result = ob_slot_r[ob_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (s2_done) begin
      ob_slot_r[ob_wr_ptr_r] <= s2_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_ptr_r <= 1'b0;
      ob_rd_ptr_r <= 1'b0;
      ob_count_r  <= 2'd0;
    end else begin
      if (s2_done) begin
        ob_wr_ptr_r <= !ob_wr_ptr_r;
      end
      if (ob_pop) begin
        ob_rd_ptr_r <= !ob_rd_ptr_r;
      end
      unique case ({s2_done, ob_pop})
        2'b10:   ob_count_r <= ob_count_r + 2'd1;
        2'b01:   ob_count_r <= ob_count_r - 2'd1;
        default: ob_count_r <= ob_count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/png_scanline_unfilter_core.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core: PNG scanline filter reconstruction
// Top level joining the intake front end, the item queue and the
// reconstruction back end with its row buffer.
// ----------------------------------------------------------------------------
// The core takes the inflated PNG byte stream one byte per clock cycle and
// sustains that rate while neither side stalls: a row's filter type byte
// yields no result, and every row byte after it yields one reconstructed byte.
// An accepted byte passes the item queue, the reconstruction stage register and
// the output buffer. The rate is set by the reconstruction stage, which keeps
// each result as left history for the next byte, and by the row buffer, which
// is read and written once per cycle. Both sides look like queues, so either
// side may stall without losing bytes. Rows up to MAX_ROW_BYTES bytes long are
// supported; the row buffer needs no clearing after reset. Write the
// geometry registers only while the core is idle.
`default_nettype none

module png_scanline_unfilter_core
  import pngu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [BYTE_W-1:0]     in_byte,
  output logic                       in_full,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic [BYTE_W-1:0]          out_byte,
  output logic                       out_row_end,
  output logic                       out_image_end,
  output logic                       out_unknown_filter,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  item_t   q_item;
  item_t   q_head;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  result_t out_result;

  // Intake and classification.
  pngu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_byte   (in_byte),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  // Queue between front and back.
  pngu_item_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Reconstruction and output buffering.
  pngu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (out_result)
  );

  assign out_byte           = out_result.data;
  assign out_row_end        = out_result.row_end;
  assign out_image_end      = out_result.image_end;
  assign out_unknown_filter = out_result.unknown;

endmodule

`default_nettype wire

// ----- rtl/pngu_checker.sv -----
// ----------------------------------------------------------------------------
// pngu_checker: port-level assertions for the scanline unfilter
// Watches the top level's ports for reset behavior, flag consistency and a
// stable waiting result, and is bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_checker
  import pngu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_full,
  input  wire logic                  out_empty,
  input  wire logic                  out_pop,
  input  wire logic [BYTE_W-1:0]     out_byte,
  input  wire logic                  out_row_end,
  input  wire logic                  out_image_end,
  input  wire logic                  out_unknown_filter
);

  // Coming out of reset, no result waits.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Coming out of reset, the core waits for a filter type byte and takes it.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // The last byte of an image is always the last byte of a row.
  a_image_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_image_end) |-> out_row_end)
    else $error("image end without row end");

  // A waiting result that is not taken holds still.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte) &&
      $stable(out_row_end) && $stable(out_image_end) && $stable(out_unknown_filter)))
    else $error("waiting result changed before it was taken");

endmodule

bind png_scanline_unfilter_core pngu_checker u_checker (.*);

`default_nettype wire
